>>> design/pli_pkg.sv
`default_nettype none

package pli_pkg;

    // List geometry.
    localparam int DEPTH    = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W    = $clog2(DEPTH + 1);

    // Field widths of the stream items.
    localparam int CMD_W    = 2;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 5;
    localparam int CMP_W    = POS_W + 1;

    localparam int IN_BITS   = CMD_W + WORD_W + POS_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STATUS_W + WORD_W + LENGTH_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [IDX_W-1:0]   idx;
        logic [WORD_W-1:0]  value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> design/pli_cell.sv
`default_nettype none

// One storage cell of the list. It compares its own index with the
// broadcast target and either keeps its word, loads the new word, or
// takes the word of its left or right neighbor.
module pli_cell (
    input  wire                          i_clk,
    input  wire  [pli_pkg::IDX_W-1:0]    i_index,
    input  pli_pkg::t_cell_ctrl          i_ctrl,
    input  wire  [pli_pkg::WORD_W-1:0]   i_left,
    input  wire  [pli_pkg::WORD_W-1:0]   i_right,
    output logic [pli_pkg::WORD_W-1:0]   o_word
);

    logic [pli_pkg::WORD_W-1:0] r_word;
    logic [pli_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.ins) begin
            if (i_index == i_ctrl.idx) begin
                n_word = i_ctrl.value;
            end else if (i_index > i_ctrl.idx) begin
                n_word = i_left;
            end
        end else if (i_ctrl.del) begin
            if (i_index >= i_ctrl.idx) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

>>> design/positional_list_insert_delete.sv
// The result of a command is registered and presented in the cycle after its transfer is accepted.
// Throughput: one command per cycle; the row of cells shifts as the command is taken, and the
// input is taken whenever the output register is empty or being drained in the same cycle.
// Reset (synchronous, active low) empties the list and drops any pending result;
// the cell words themselves are not reset.
`default_nettype none

module positional_list_insert_delete (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Command stream.
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata from bit 0: command[1:0], value[33:2], position[41:34], zero fill.
    input  wire  [pli_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // Result stream.
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // tdata from bit 0: status[1:0], read_value[33:2], length[38:34], zero fill.
    output logic [pli_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    // Unpacked command fields.
    logic [pli_pkg::CMD_W-1:0]    w_cmd;
    logic [pli_pkg::WORD_W-1:0]   w_value;
    logic [pli_pkg::POS_W-1:0]    w_pos;

    assign w_cmd   = i_s_axis_tdata[pli_pkg::CMD_W-1:0];
    assign w_value = i_s_axis_tdata[pli_pkg::CMD_W +: pli_pkg::WORD_W];
    assign w_pos   = i_s_axis_tdata[pli_pkg::CMD_W + pli_pkg::WORD_W +: pli_pkg::POS_W];

    // Element count and the output register.
    logic [pli_pkg::LEN_W-1:0]    r_count;
    logic [pli_pkg::LEN_W-1:0]    n_count;
    logic                         r_out_valid;
    logic [pli_pkg::STATUS_W-1:0] r_status;
    logic [pli_pkg::WORD_W-1:0]   r_read_value;
    logic [pli_pkg::LEN_W-1:0]    r_length;

    logic w_accept;

    // The input is free whenever the output slot is empty or is handed on now.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Command decode. Positions are compared one bit wider than the field so
    // that count + 1 never wraps.
    logic [pli_pkg::CMP_W-1:0]    w_pos_ext;
    logic [pli_pkg::CMP_W-1:0]    w_cnt_ext;
    logic [pli_pkg::POS_W-1:0]    w_pos_m1;
    logic                         w_full;
    logic                         w_empty;
    logic [pli_pkg::STATUS_W-1:0] w_status;
    logic                         w_do_ins;
    logic                         w_do_del;
    logic                         w_do_read;
    logic [pli_pkg::IDX_W-1:0]    w_idx;

    assign w_pos_ext = {1'b0, w_pos};
    assign w_cnt_ext = pli_pkg::CMP_W'(r_count);
    assign w_pos_m1  = w_pos - 1'b1;
    assign w_full    = (r_count == pli_pkg::LEN_W'(pli_pkg::DEPTH));
    assign w_empty   = (r_count == '0);

    always_comb begin
        w_status  = pli_pkg::ST_OK;
        w_do_ins  = 1'b0;
        w_do_del  = 1'b0;
        w_do_read = 1'b0;
        w_idx     = pli_pkg::IDX_W'(w_pos_m1);
        case (w_cmd)
            pli_pkg::CMD_APPEND: begin
                // Append is an insert at the slot just past the tail.
                w_idx = pli_pkg::IDX_W'(r_count);
                if (w_full) begin
                    w_status = pli_pkg::ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            pli_pkg::CMD_INSERT: begin
                if (w_pos == '0 || w_pos_ext > w_cnt_ext + 1'b1) begin
                    w_status = pli_pkg::ST_BADPOS;
                end else if (w_full) begin
                    w_status = pli_pkg::ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            pli_pkg::CMD_DELETE, pli_pkg::CMD_READ: begin
                if (w_empty) begin
                    w_status = pli_pkg::ST_EMPTY;
                end else if (w_pos == '0 || w_pos_ext > w_cnt_ext) begin
                    w_status = pli_pkg::ST_BADPOS;
                end else if (w_cmd == pli_pkg::CMD_DELETE) begin
                    w_do_del = 1'b1;
                end else begin
                    w_do_read = 1'b1;
                end
            end
            default: begin
                w_status = pli_pkg::ST_OK;
            end
        endcase
    end

    // Control broadcast along the row; nothing moves unless a transfer is taken.
    pli_pkg::t_cell_ctrl w_ctrl;

    assign w_ctrl.ins   = w_accept && w_do_ins;
    assign w_ctrl.del   = w_accept && w_do_del;
    assign w_ctrl.idx   = w_idx;
    assign w_ctrl.value = w_value;

    // The row of cells. Each cell sees its left and right neighbor; the first
    // cell never shifts from the left and the last one refills from itself on
    // a delete, which leaves a stale word beyond the tail that is never read.
    logic [pli_pkg::WORD_W-1:0] w_words [pli_pkg::DEPTH];

    for (genvar k = 0; k < pli_pkg::DEPTH; k++) begin : g_cell
        logic [pli_pkg::WORD_W-1:0] w_left;
        logic [pli_pkg::WORD_W-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = w_value;
        end else begin : g_mid_l
            assign w_left = w_words[k-1];
        end

        if (k == pli_pkg::DEPTH - 1) begin : g_last
            assign w_right = w_words[k];
        end else begin : g_mid_r
            assign w_right = w_words[k+1];
        end

        pli_cell u_cell (
            .i_clk   (i_clk),
            .i_index (pli_pkg::IDX_W'(k)),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_words[k])
        );
    end

    // Read port: one selection over the row, used only for a valid read.
    logic [pli_pkg::WORD_W-1:0] w_read_word;

    assign w_read_word = w_do_read ? w_words[w_idx] : '0;

    // Next count.
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.del) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload is captured with the command that produced it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= w_status;
            r_read_value <= w_read_word;
            r_length     <= n_count;
        end
    end

    logic [pli_pkg::CMP_W-1:0] w_length_ext;

    assign w_length_ext    = pli_pkg::CMP_W'(r_length);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = pli_pkg::OUT_DATA_W'({w_length_ext[pli_pkg::LENGTH_W-1:0],
                                                   r_read_value, r_status});

endmodule

`default_nettype wire

>>> tb/positional_list_checker.sv
module positional_list_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Command channel as seen at the block's slave side.
    input  wire                             i_cmd_tvalid,
    input  wire                             i_cmd_tready,
    // tdata from bit 0: command[1:0], value[33:2], position[41:34], zero fill.
    input  wire  [pli_pkg::IN_DATA_W-1:0]   i_cmd_tdata,
    // Result channel as seen at the block's master side.
    input  wire                             i_res_tvalid,
    input  wire                             i_res_tready,
    // tdata from bit 0: status[1:0], read_value[33:2], length[38:34], zero fill.
    input  wire  [pli_pkg::OUT_DATA_W-1:0]  i_res_tdata,
    output int                              o_errors,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word;
        logic [LENGTH_W-1:0] len;
    } list_reply_t;

    // Shadow copy of the list and the replies it still owes.
    logic [WORD_W-1:0] list_words [DEPTH];
    int                list_len = 0;
    list_reply_t       awaited_replies [$];
    int                error_count = 0;

    // Applies one command to the shadow list and returns the reply it must produce.
    function automatic list_reply_t predict_list_command(input logic [CMD_W-1:0] cmd,
                                                         input logic [WORD_W-1:0] word,
                                                         input logic [POS_W-1:0] pos);
        list_reply_t r;
        int          p;
        int          i;
        r.status = ST_OK;
        r.word   = '0;
        p        = int'(pos);
        case (cmd)
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            CMD_INSERT: begin
                // A bad position wins over a full list.
                if (p == 0 || p > list_len + 1) begin
                    r.status = ST_BADPOS;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > p - 1; i--) list_words[i] = list_words[i-1];
                    list_words[p-1] = word;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                // An empty list wins over a bad position.
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (p == 0 || p > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (i = p - 1; i < list_len - 1; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            default: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (p == 0 || p > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.word = list_words[p-1];
                end
            end
        endcase
        r.len = list_len[LENGTH_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        list_reply_t got;
        list_reply_t want;
        if (!i_rst_n) begin
            list_len = 0;
            awaited_replies.delete();
        end else begin
            if (i_res_tvalid && i_res_tready) begin
                got.status = i_res_tdata[1:0];
                got.word   = i_res_tdata[33:2];
                got.len    = i_res_tdata[38:34];
                if (awaited_replies.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: status %0d value %h length %0d",
                             $time, got.status, got.word, got.len);
                end else begin
                    want = awaited_replies.pop_front();
                    if (got !== want || i_res_tdata[OUT_DATA_W-1:OUT_BITS] !== '0) begin
                        error_count++;
                        $display("%0t: mismatch: expected status %0d value %h length %0d",
                                 $time, want.status, want.word, want.len);
                        $display("%0t:           actual status %0d value %h length %0d fill %b",
                                 $time, got.status, got.word, got.len,
                                 i_res_tdata[OUT_DATA_W-1:OUT_BITS]);
                    end
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                awaited_replies.push_back(predict_list_command(i_cmd_tdata[1:0],
                                                               i_cmd_tdata[33:2],
                                                               i_cmd_tdata[41:34]));
            end
        end
        o_pending <= awaited_replies.size();
        o_errors  <= error_count;
    end

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    // Clock, reset and the two stream channels. Every input of the block starts at
    // a known value: no valid command, receiver ready.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // tdata from bit 0: command[1:0], value[33:2], position[41:34], zero fill.
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    // tdata from bit 0: status[1:0], read_value[33:2], length[38:34], zero fill.
    logic [OUT_DATA_W-1:0] m_tdata;

    int                    error_total;
    int                    replies_owed;

    // Percent of cycles in which the sender holds back and the receiver stalls.
    int                    idle_pct = 0;
    int                    stall_pct = 0;

    positional_list_insert_delete dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // The checker watches both channels, keeps its own copy of the list and compares
    // every result transfer with the reply it predicted.
    positional_list_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (s_tvalid),
        .i_cmd_tready (s_tready),
        .i_cmd_tdata  (s_tdata),
        .i_res_tvalid (m_tvalid),
        .i_res_tready (m_tready),
        .i_res_tdata  (m_tdata),
        .o_errors     (error_total),
        .o_pending    (replies_owed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver draws a fresh ready every cycle, stalling as often as the current
    // phase asks.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offers one command and returns at the edge where its transfer takes place.
    // Idle cycles are inserted in front of it at the current rate. Each call makes
    // exactly one assignment to the valid in any one time step, so a valid that stays
    // high between back-to-back commands is never dropped and raised in the same step.
    task automatic send_list_command(input logic [CMD_W-1:0] cmd,
                                     input logic [WORD_W-1:0] word,
                                     input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, pos, word, cmd};
        do @(posedge i_clk); while (!s_tready);
    endtask

    initial begin
        int                n;
        int                k;
        int                roll;
        bit                grow;
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;

        // Synchronous reset at the start, released once and never asserted again.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with no idling. Empty list first: read and delete report an
        // empty list, and an insert at position zero or past the tail is a bad position.
        send_list_command(CMD_READ,   32'h1234_5678, 8'd1);
        send_list_command(CMD_DELETE, 32'h0,         8'd0);
        send_list_command(CMD_INSERT, 32'h5555_5555, 8'd0);
        send_list_command(CMD_INSERT, 32'hAAAA_AAAA, 8'd2);
        // Build a short list with the extreme words, inserting at the head, at the
        // tail (position count+1) and in the middle.
        send_list_command(CMD_INSERT, 32'h8000_0000, 8'd1);
        send_list_command(CMD_APPEND, 32'h7FFF_FFFF, 8'd255);
        send_list_command(CMD_INSERT, 32'hFFFF_FFFF, 8'd3);
        send_list_command(CMD_INSERT, 32'h0000_0000, 8'd2);
        send_list_command(CMD_READ,   32'h0,         8'd4);
        send_list_command(CMD_READ,   32'h0,         8'd0);
        send_list_command(CMD_READ,   32'h0,         8'd5);
        send_list_command(CMD_DELETE, 32'h0,         8'd255);
        send_list_command(CMD_DELETE, 32'h0,         8'd2);
        send_list_command(CMD_READ,   32'h0,         8'd2);
        // Fill the list to the brim, then hit it while full: append and a valid insert
        // report a full list, while a bad insert position still wins over full.
        for (k = 3; k < DEPTH; k++) send_list_command(CMD_APPEND, $urandom, 8'd0);
        send_list_command(CMD_APPEND, 32'h0BAD_F00D, 8'd0);
        send_list_command(CMD_INSERT, 32'h0BAD_F00D, 8'd17);
        send_list_command(CMD_INSERT, 32'h0BAD_F00D, 8'd18);
        send_list_command(CMD_READ,   32'h0,         8'd16);

        // Random part. The flow-control phase changes every 150 commands, and every
        // 40 commands the mix swings between growing and shrinking the list so that it
        // keeps passing through both the empty and the full state.
        for (n = 0; n < 1850; n++) begin
            if (n % 150 == 0) begin
                case ((n / 150) % 4)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 78; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 78; end
                    default: begin idle_pct = 13; stall_pct = 13; end
                endcase
            end
            grow = ((n / 40) % 2 == 0);
            roll = $urandom_range(99);
            if (grow) begin
                cmd = (roll < 35) ? CMD_APPEND : (roll < 65) ? CMD_INSERT :
                      (roll < 80) ? CMD_DELETE : CMD_READ;
            end else begin
                cmd = (roll < 10) ? CMD_APPEND : (roll < 25) ? CMD_INSERT :
                      (roll < 65) ? CMD_DELETE : CMD_READ;
            end
            // Words: mostly random, with the sign and all-ones/all-zeros extremes mixed in.
            case ($urandom_range(9))
                0: word = 32'h8000_0000;
                1: word = 32'h7FFF_FFFF;
                2: word = 32'h0000_0000;
                3: word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            // Positions: mostly around the live range so that most are valid, now and
            // then anything the field can carry.
            if ($urandom_range(9) == 0) begin
                pos = POS_W'($urandom_range(255));
            end else begin
                pos = POS_W'($urandom_range(DEPTH + 2));
            end
            send_list_command(cmd, word, pos);
        end
        s_tvalid <= 1'b0;

        // Let the last results drain, then keep the clock running so that the block can show a
        // stray transfer. A reply still owed after the bound counts as a failure.
        k = 0;
        do begin
            @(posedge i_clk);
            k++;
        end while (replies_owed != 0 && k < 20000);
        repeat (8) @(posedge i_clk);

        if (error_total == 0 && replies_owed == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, which stays well under half a
    // millisecond even with the heaviest idling.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
